[rtl/assert_macros.svh]
// Assertion macros for the RTL core, which checks its own behavior with them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWME_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define RWME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

[rtl/rwme_pkg.sv]
`default_nettype none

package rwme_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int MOD_W         = 63;
    localparam int CNT_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int COUNT_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 63'd2;
    localparam logic [MOD_W-1:0] EXP_RESET     = 63'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXP,
        ST_DBL,
        ST_ADD,
        ST_MEND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic load_item;
        logic reduce_step;
        logic reduce_end;
        logic start_mul;
        logic mul_sq;
        logic dbl;
        logic add;
        logic advance;
        logic take_res;
        logic take_base;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic mod_small;
        logic exp_zero;
        logic exp_lsb;
        logic mplier_msb;
        logic cnt_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/rwme_mod_adder.sv]
`default_nettype none

module rwme_mod_adder (
    input  wire logic [rwme_pkg::MOD_W-1:0] i_x,
    input  wire logic [rwme_pkg::MOD_W-1:0] i_y,
    input  wire logic                       i_cin,
    input  wire logic [rwme_pkg::MOD_W-1:0] i_mod,
    output logic      [rwme_pkg::MOD_W-1:0] o_sum
);
    import rwme_pkg::*;

    logic [MOD_W:0] sum;
    logic [MOD_W:0] diff;

    // Both operands are below the modulus, so one conditional subtract is enough.
    always_comb begin
        sum   = {1'b0, i_x} + {1'b0, i_y} + {{MOD_W{1'b0}}, i_cin};
        diff  = sum - {1'b0, i_mod};
        o_sum = (sum >= {1'b0, i_mod}) ? diff[MOD_W-1:0] : sum[MOD_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/rwme_seq.sv]
`default_nettype none

module rwme_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rwme_pkg::t_stat i_stat,
    output rwme_pkg::t_ctrl      o_ctrl
);
    import rwme_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_sq;
    logic   n_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sq    <= n_sq;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sq    = r_sq;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.in_fire) begin
                    n_state = i_stat.mod_small ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (i_stat.cnt_last) begin
                    n_state = ST_EXP;
                end
            end
            ST_EXP: begin
                if (i_stat.exp_zero) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DBL;
                    n_sq    = ~i_stat.exp_lsb;
                end
            end
            ST_DBL: begin
                if (i_stat.mplier_msb) begin
                    n_state = ST_ADD;
                end else if (i_stat.cnt_last) begin
                    n_state = ST_MEND;
                end
            end
            ST_ADD: begin
                n_state = i_stat.cnt_last ? ST_MEND : ST_DBL;
            end
            ST_MEND: begin
                if (r_sq) begin
                    n_state = ST_EXP;
                end else begin
                    n_state = ST_DBL;
                    n_sq    = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl      = '0;
        o_ctrl.busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.load_item = i_stat.in_fire;
            end
            ST_REDUCE: begin
                o_ctrl.reduce_step = 1'b1;
                o_ctrl.reduce_end  = i_stat.cnt_last;
            end
            ST_EXP: begin
                o_ctrl.start_mul = ~i_stat.exp_zero;
                o_ctrl.mul_sq    = ~i_stat.exp_lsb;
            end
            ST_DBL: begin
                o_ctrl.dbl     = 1'b1;
                o_ctrl.advance = ~i_stat.mplier_msb;
            end
            ST_ADD: begin
                o_ctrl.add     = 1'b1;
                o_ctrl.advance = 1'b1;
            end
            ST_MEND: begin
                o_ctrl.take_base = r_sq;
                o_ctrl.take_res  = ~r_sq;
                o_ctrl.start_mul = ~r_sq;
                o_ctrl.mul_sq    = 1'b1;
            end
            ST_DONE: begin
                o_ctrl.load_out = i_stat.out_free;
            end
            default: begin
                o_ctrl.busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/rsa_word_modular_exponent_core.sv]
// The word is first reduced modulo the modulus bit by bit; then, while exponent bits remain,
// each bit takes a square, and a multiply only for a set bit; each modular multiply is done by
// double-and-add over the multiplier bits on the shared modular adder. One item is in
// flight at a time; the next is taken once the result sits in the output register. Reset
// is synchronous, active low: the modulus returns to 2, both exponents to 1, the output
// register is emptied and no transfer is taken.
`default_nettype none

module rsa_word_modular_exponent_core #(
    parameter int WORD_BITS = rwme_pkg::WORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_op,
    input  wire logic [WORD_BITS-1:0]             i_data_word,
    input  wire logic [rwme_pkg::COUNT_W-1:0]     i_byte_count,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [WORD_BITS-1:0]             o_result_word,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rwme_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rwme_pkg::MOD_W-1:0]       i_cfg_data
);
    import rwme_pkg::*;

    localparam int BYTE_LIM = WORD_BITS / 8;

    t_ctrl ctrl;
    t_stat stat;

    logic [MOD_W-1:0]     r_mod;
    logic [MOD_W-1:0]     r_pub;
    logic [MOD_W-1:0]     r_priv;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] r_mask;
    logic [MOD_W-1:0]     r_exp;
    logic [MOD_W-1:0]     r_base;
    logic [MOD_W-1:0]     r_res;
    logic [MOD_W-1:0]     r_acc;
    logic [MOD_W-1:0]     r_mplier;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_out;
    logic                 r_out_valid;

    logic [MOD_W-1:0]     n_acc;
    logic [MOD_W-1:0]     add_y;
    logic                 add_cin;
    logic [COUNT_W-1:0]   count_eff;
    logic [WORD_BITS-1:0] in_mask;
    logic [63:0]          res_ext;

    assign o_cfg_ready   = i_rst_n;
    assign o_in_stall    = ctrl.busy | ~i_rst_n;
    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_out;

    always_comb begin
        count_eff = (i_byte_count > COUNT_W'(BYTE_LIM)) ? COUNT_W'(BYTE_LIM) : i_byte_count;
        for (int i = 0; i < WORD_BITS; i++) begin
            in_mask[i] = ((i >> 3) < BYTE_LIM) && (COUNT_W'(i >> 3) < count_eff);
        end
    end

    always_comb begin
        stat.in_fire    = i_in_valid & ~o_in_stall;
        stat.mod_small  = (r_mod[MOD_W-1:1] == '0);
        stat.exp_zero   = (r_exp == '0);
        stat.exp_lsb    = r_exp[0];
        stat.mplier_msb = r_mplier[MOD_W-1];
        stat.cnt_last   = (r_cnt == CNT_W'(1));
        stat.out_free   = ~r_out_valid | ~i_out_stall;
    end

    rwme_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    assign add_y   = ctrl.add ? r_base : r_acc;
    assign add_cin = ctrl.reduce_step & r_word[WORD_BITS-1];

    rwme_mod_adder u_adder (
        .i_x   (r_acc),
        .i_y   (add_y),
        .i_cin (add_cin),
        .i_mod (r_mod),
        .o_sum (n_acc)
    );

    assign res_ext = {1'b0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= MODULUS_RESET;
            r_pub       <= EXP_RESET;
            r_priv      <= EXP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MODULUS:     r_mod  <= i_cfg_data;
                    CFG_PUBLIC_EXP:  r_pub  <= i_cfg_data;
                    CFG_PRIVATE_EXP: r_priv <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_item) begin
            r_word <= i_data_word & in_mask;
            r_mask <= in_mask;
            r_exp  <= i_op ? r_priv : r_pub;
            r_res  <= '0;
            r_acc  <= '0;
            r_cnt  <= CNT_W'(WORD_BITS);
        end
        if (ctrl.reduce_step) begin
            r_word <= {r_word[WORD_BITS-2:0], 1'b0};
            r_acc  <= n_acc;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
        if (ctrl.reduce_end) begin
            r_base <= n_acc;
            r_res  <= MOD_W'(1);
        end
        if (ctrl.dbl || ctrl.add) begin
            r_acc <= n_acc;
        end
        if (ctrl.advance) begin
            r_mplier <= {r_mplier[MOD_W-2:0], 1'b0};
            r_cnt    <= r_cnt - CNT_W'(1);
        end
        if (ctrl.take_res) begin
            r_res <= r_acc;
        end
        if (ctrl.take_base) begin
            r_base <= r_acc;
            r_exp  <= {1'b0, r_exp[MOD_W-1:1]};
        end
        if (ctrl.start_mul) begin
            r_acc    <= '0;
            r_cnt    <= CNT_W'(MOD_W);
            r_mplier <= ctrl.mul_sq ? r_base : r_res;
        end
        if (ctrl.load_out) begin
            r_out <= res_ext[WORD_BITS-1:0] & r_mask;
        end
    end

    `include "assert_macros.svh"

    `RWME_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `RWME_ASSERT_NEXT(a_out_after_load, i_clk, i_rst_n, ctrl.load_out, o_out_valid && !o_in_stall)
    `RWME_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !ctrl.load_out, !o_out_valid)
    `RWME_ASSERT_IMPL(a_add_after_dbl, i_clk, i_rst_n, ctrl.add, $past(ctrl.dbl))

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
    import rwme_pkg::*;

    localparam int          WB          = WORD_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int unsigned HOLDOFF_LEN = 30_000;
    localparam int unsigned TAIL_CYCLES = 200;

    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic                   op;
        logic [WB-1:0]          word;
        logic [COUNT_W-1:0]     count;
        logic [CFG_IDX_W-1:0]   index;
        logic [MOD_W-1:0]       data;
    } t_job;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   i_op         = 1'b0;
    logic [WB-1:0]          i_data_word  = '0;
    logic [COUNT_W-1:0]     i_byte_count = '0;
    logic                   i_out_stall  = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index  = CFG_MODULUS;
    logic [MOD_W-1:0]       i_cfg_data   = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [WB-1:0]          o_result_word;
    logic                   o_cfg_ready;

    t_job                   jobs[$];
    logic [WB-1:0]          expected_words[$];
    logic [MOD_W-1:0]       cur_modulus = MODULUS_RESET;
    logic [MOD_W-1:0]       cur_pub_exp = EXP_RESET;
    logic [MOD_W-1:0]       cur_priv_exp = EXP_RESET;
    int unsigned            cycle_count = 0;
    int unsigned            mismatches = 0;
    int unsigned            results_seen = 0;
    int unsigned            holdoff_at = 0;
    int unsigned            send_gap = 0;
    int unsigned            stall_left = 0;
    int unsigned            holdoff_left = 0;
    logic                   holdoff_done = 1'b0;
    logic                   quiet = 1'b0;

    rsa_word_modular_exponent_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_word (o_result_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [WB-1:0] modexp_word(logic op, logic [WB-1:0] word,
                                                  logic [COUNT_W-1:0] count);
        logic [WB-1:0]    msk;
        logic [127:0]     m;
        logic [127:0]     acc;
        logic [127:0]     base;
        logic [MOD_W-1:0] ex;
        int               n;
        n   = (count > WB / 8) ? WB / 8 : count;
        msk = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        ex  = op ? cur_priv_exp : cur_pub_exp;
        if (cur_modulus < 2) begin
            return '0;
        end
        m    = {65'd0, cur_modulus};
        acc  = 128'd1;
        base = {64'd0, word & msk} % m;
        for (int i = 0; i < MOD_W; i++) begin
            if (ex[i]) begin
                acc = (acc * base) % m;
            end
            base = (base * base) % m;
        end
        return acc[WB-1:0] & msk;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_item(logic op, logic [WB-1:0] word, logic [COUNT_W-1:0] count);
        t_job j;
        j       = '0;
        j.kind  = JOB_ITEM;
        j.op    = op;
        j.word  = word;
        j.count = count;
        jobs.push_back(j);
    endtask

    task automatic add_key(logic [MOD_W-1:0] modv, logic [MOD_W-1:0] pubv,
                           logic [MOD_W-1:0] privv);
        t_job j;
        j       = '0;
        j.kind  = JOB_CFG;
        j.index = CFG_MODULUS;
        j.data  = modv;
        jobs.push_back(j);
        j.index = CFG_PUBLIC_EXP;
        j.data  = pubv;
        jobs.push_back(j);
        j.index = CFG_PRIVATE_EXP;
        j.data  = privv;
        jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j      = '0;
        j.kind = JOB_DRAIN;
        jobs.push_back(j);
    endtask

    task automatic add_random_item();
        logic [COUNT_W-1:0] cnt;
        if ($urandom_range(0, 99) < 85) begin
            cnt = COUNT_W'($urandom_range(1, 8));
        end else begin
            cnt = COUNT_W'($urandom_range(0, 15));
        end
        add_item(1'($urandom_range(0, 1)), rand64(), cnt);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0) begin
            quiet <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rsa_word_modular_exponent_core: mismatch");
            $finish;
        end
    end

    // Sender: offers the job at the head of the queue; key writes and drain
    // points wait until every expected result has come back.
    always @(posedge i_clk) begin : send_proc
        logic hold_in;
        logic hold_cfg;
        logic next_in_valid;
        logic next_cfg_valid;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            hold_in  = i_in_valid && o_in_stall;
            hold_cfg = i_cfg_valid && !o_cfg_ready;
            if (i_in_valid && !o_in_stall) begin
                expected_words.push_back(modexp_word(jobs[0].op, jobs[0].word,
                                                     jobs[0].count));
                void'(jobs.pop_front());
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (jobs[0].index)
                    CFG_MODULUS:     cur_modulus  = jobs[0].data;
                    CFG_PUBLIC_EXP:  cur_pub_exp  = jobs[0].data;
                    CFG_PRIVATE_EXP: cur_priv_exp = jobs[0].data;
                    default: ;
                endcase
                void'(jobs.pop_front());
            end
            next_in_valid  = hold_in;
            next_cfg_valid = hold_cfg;
            if (!hold_in && !hold_cfg) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else if (jobs.size() != 0) begin
                    case (jobs[0].kind)
                        JOB_ITEM: begin
                            next_in_valid = 1'b1;
                            i_op         <= jobs[0].op;
                            i_data_word  <= jobs[0].word;
                            i_byte_count <= jobs[0].count;
                            send_gap     <= pick_gap();
                        end
                        JOB_CFG: begin
                            if (expected_words.size() == 0) begin
                                next_cfg_valid = 1'b1;
                                i_cfg_index   <= jobs[0].index;
                                i_cfg_data    <= jobs[0].data;
                            end
                        end
                        default: begin
                            if (expected_words.size() == 0) begin
                                void'(jobs.pop_front());
                            end
                        end
                    endcase
                end
            end
            i_in_valid  <= next_in_valid;
            i_cfg_valid <= next_cfg_valid;
        end
    end

    // Receiver: checks each result transfer and stalls at random, with one
    // long hold-off so that the block fills and stalls its input.
    always @(posedge i_clk) begin : recv_proc
        logic [WB-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen = results_seen + 1;
                if (expected_words.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result %h", o_result_word);
                    end
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (o_result_word !== want) begin
                        if (mismatches < 10) begin
                            $display("result %0d: expected %h, got %h", results_seen,
                                     want, o_result_word);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
                i_out_stall  <= 1'b1;
            end else if (!holdoff_done && holdoff_at != 0 && results_seen == holdoff_at) begin
                holdoff_done <= 1'b1;
                holdoff_left <= HOLDOFF_LEN;
                i_out_stall  <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0) begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    initial begin : stim_proc
        logic [MOD_W-1:0] modv;
        logic [MOD_W-1:0] pubv;
        logic [MOD_W-1:0] privv;
        int unsigned      n_items;

        // Reset values of the key: modulus two, both exponents one.
        add_item(1'b0, '1, 4'd8);
        add_item(1'b1, '0, 4'd1);
        add_item(1'b0, rand64(), 4'd0);
        add_item(1'b1, '1, 4'd15);
        add_drain();

        // Largest modulus, largest public exponent, zero private exponent.
        add_key('1, '1, '0);
        add_item(1'b0, '1, 4'd8);
        add_item(1'b1, rand64(), 4'd3);
        add_item(1'b0, 64'h8000_0000_0000_0001, 4'd9);
        add_item(1'b0, '0, 4'd8);
        add_item(1'b1, '1, 4'd8);

        // Degenerate moduli give zero.
        add_key(63'd1, 63'd5, 63'd7);
        add_item(1'b0, 64'd3, 4'd8);
        add_item(1'b1, '1, 4'd8);
        add_key(63'd0, 63'd5, 63'd7);
        add_item(1'b0, 64'd3, 4'd8);
        add_item(1'b1, '1, 4'd8);

        // A textbook key pair: the decrypted word returns the plaintext, and
        // a one-byte count cuts a residue that needs two bytes.
        add_key(63'd3233, 63'd17, 63'd2753);
        add_item(1'b0, 64'd65, 4'd2);
        add_item(1'b1, 64'd2790, 4'd2);
        add_item(1'b0, 64'd65, 4'd1);
        add_item(1'b1, 64'hFFFF_FFFF_FFFF_0CA6, 4'd2);

        add_key(63'h7FFF_FFFF_FFFF_FFE7, 63'd65537, 63'(rand64()));
        add_item(1'b0, rand64(), 4'd8);
        add_item(1'b1, rand64(), 4'd8);
        add_item(1'b0, rand64(), 4'd7);
        n_items = 23;

        for (int p = 0; p < 8; p++) begin
            case (p % 3)
                0:       modv = 63'($urandom_range(2, 5000));
                1:       modv = 63'(rand64()) | (63'd1 << 62);
                default: modv = 63'(rand64());
            endcase
            if (modv < 2) begin
                modv = 63'd2;
            end
            if (p % 4 == 3) begin
                pubv  = 63'(rand64());
                privv = 63'(rand64()) | (63'd1 << 62);
            end else begin
                pubv  = 63'($urandom_range(0, 65535));
                privv = 63'($urandom_range(0, 4095));
            end
            add_key(modv, pubv, privv);
            if (p == 1) begin
                holdoff_at = n_items + 1;
            end
            for (int k = 0; k < 12; k++) begin
                add_random_item();
                n_items++;
                if (p != 1 && k == 5) begin
                    add_drain();
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs.size() != 0 || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("rsa_word_modular_exponent_core: match");
        end else begin
            $display("rsa_word_modular_exponent_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
